@@ rtl/core/fsc_pkg.sv @@
// ----------------------------------------------------------------------------
// fsc_pkg: shared types and constants of the frustum sphere culling core
// Widths of the fixed-point datapath, the item record that moves along the
// plane cells, the register map and the plane extraction function.
// ----------------------------------------------------------------------------
package fsc_pkg;

    // Plane count limits and the register file geometry.
    localparam int PLANE_MAX   = 6;
    localparam int COL_W       = 64;
    localparam int ROW_W       = 16;
    localparam int ROWS        = 4;
    localparam int CFG_IDX_W   = 2;

    // Item fields.
    localparam int POS_W       = 24;
    localparam int RAD_W       = 23;
    localparam int FRAC_W      = 12;

    // Datapath widths. A plane coefficient is the sum of two Q4.12 values.
    localparam int COEF_W      = ROW_W + 1;
    localparam int SQ_W        = 2 * COEF_W;
    localparam int NN_W        = 2 * COEF_W;
    localparam int R2_W        = 2 * RAD_W;
    localparam int PROD_W      = COEF_W + POS_W;
    localparam int D_W         = PROD_W + 2;
    localparam int AD_W        = D_W - 1;
    localparam int AL_W        = AD_W / 2;
    localparam int AH_W        = AD_W - AL_W;
    localparam int DPP_W       = 2 * AH_W;
    localparam int RL_W        = R2_W / 2;
    localparam int RH_W        = R2_W - RL_W;
    localparam int RPP_W       = RH_W + NN_W;
    localparam int SQR_W       = 2 * AD_W;

    // Pipeline depth of one plane cell.
    localparam int CELL_STAGES = 6;

    // Register reset values: the identity matrix.
    localparam logic [COL_W-1:0] COL1_RESET = 64'h0000_0000_0000_1000;
    localparam logic [COL_W-1:0] COL2_RESET = 64'h0000_0000_1000_0000;
    localparam logic [COL_W-1:0] COL3_RESET = 64'h0000_1000_0000_0000;
    localparam logic [COL_W-1:0] COL4_RESET = 64'h1000_0000_0000_0000;

    // Register map.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MATRIX_COLUMN_1 = 2'd0,
        CFG_MATRIX_COLUMN_2 = 2'd1,
        CFG_MATRIX_COLUMN_3 = 2'd2,
        CFG_MATRIX_COLUMN_4 = 2'd3
    } cfg_reg_t;

    // One frustum plane: normal and offset in Q5.12.
    typedef struct packed {
        logic signed [COEF_W-1:0] nx;
        logic signed [COEF_W-1:0] ny;
        logic signed [COEF_W-1:0] nz;
        logic signed [COEF_W-1:0] w;
    } plane_t;

    // One object as it travels from cell to cell.
    typedef struct packed {
        logic                    valid;
        logic                    has_sphere;
        logic                    visible;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic [R2_W-1:0]         r2;
    } item_t;

    // Builds plane idx from the matrix columns: near, far, left, right, top, bottom.
    function automatic plane_t plane_coef(
        input logic [COL_W-1:0] c1,
        input logic [COL_W-1:0] c2,
        input logic [COL_W-1:0] c3,
        input logic [COL_W-1:0] c4,
        input int unsigned      idx
    );
        logic [COL_W-1:0]         other;
        logic                     sub;
        logic signed [COEF_W-1:0] a;
        logic signed [COEF_W-1:0] b;
        logic signed [COEF_W-1:0] res [ROWS];
        plane_t                   p;
        case (idx)
            0:       begin other = c3; sub = 1'b0; end
            1:       begin other = c3; sub = 1'b1; end
            2:       begin other = c1; sub = 1'b0; end
            3:       begin other = c1; sub = 1'b1; end
            4:       begin other = c2; sub = 1'b1; end
            default: begin other = c2; sub = 1'b0; end
        endcase
        for (int k = 0; k < ROWS; k++) begin
            a = COEF_W'(signed'(c4[ROW_W*k +: ROW_W]));
            b = COEF_W'(signed'(other[ROW_W*k +: ROW_W]));
            res[k] = sub ? (a - b) : (a + b);
        end
        p.nx = res[0];
        p.ny = res[1];
        p.nz = res[2];
        p.w  = res[3];
        return p;
    endfunction

endpackage

@@ rtl/core/frustum_sphere_cull_core.sv @@
// ----------------------------------------------------------------------------
// frustum_sphere_cull_core: sphere versus view frustum visibility test
// Holds the view-projection matrix, extracts one plane per cell and streams
// objects through a chain of plane cells, one object per cycle unless the output stalls.
// ----------------------------------------------------------------------------
// Path: an accepted input passes the entry register, the six stages of each
//   plane cell and the output register on its way to out_valid.
// Throughput: one object per cycle; the whole chain holds only while a
//   finished result waits at a stalled output.
// Reset: clears all valid flags and loads the identity matrix.
// ----------------------------------------------------------------------------
module frustum_sphere_cull_core #(
    parameter int PLANE_COUNT = fsc_pkg::PLANE_MAX
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Configuration write port
    input  logic                             cfg_wr_en,
    input  logic [fsc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fsc_pkg::COL_W-1:0]        cfg_data,
    // Object input channel
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic signed [fsc_pkg::POS_W-1:0] pos_x,
    input  logic signed [fsc_pkg::POS_W-1:0] pos_y,
    input  logic signed [fsc_pkg::POS_W-1:0] pos_z,
    input  logic [fsc_pkg::RAD_W-1:0]        radius,
    input  logic                             has_sphere,
    // Result output channel
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             visible
);

    localparam int COL_W = fsc_pkg::COL_W;
    localparam int R2_W  = fsc_pkg::R2_W;

    // Matrix columns.
    logic [COL_W-1:0] col1_reg, col2_reg, col3_reg, col4_reg;

    // Pipeline control and records.
    logic                   advance;
    logic [R2_W-1:0]        r2_sq;
    fsc_pkg::item_t         entry_reg;
    fsc_pkg::item_t         entry_next;
    fsc_pkg::item_t         chain [PLANE_COUNT+1];
    logic                   out_valid_reg;
    logic                   visible_reg;

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col1_reg <= fsc_pkg::COL1_RESET;
            col2_reg <= fsc_pkg::COL2_RESET;
            col3_reg <= fsc_pkg::COL3_RESET;
            col4_reg <= fsc_pkg::COL4_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (fsc_pkg::cfg_reg_t'(cfg_index))
                fsc_pkg::CFG_MATRIX_COLUMN_1: col1_reg <= cfg_data;
                fsc_pkg::CFG_MATRIX_COLUMN_2: col2_reg <= cfg_data;
                fsc_pkg::CFG_MATRIX_COLUMN_3: col3_reg <= cfg_data;
                fsc_pkg::CFG_MATRIX_COLUMN_4: col4_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // The chain moves unless a finished result waits at a stalled output.
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = !advance;

    // Entry stage: capture the object and square its radius.
    assign r2_sq = radius * radius;

    always_comb
    begin
        entry_next.valid      = in_valid;
        entry_next.has_sphere = has_sphere;
        entry_next.visible    = 1'b1;
        entry_next.pos_x      = pos_x;
        entry_next.pos_y      = pos_y;
        entry_next.pos_z      = pos_z;
        entry_next.r2         = r2_sq;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else if (advance)
        begin
            entry_reg <= entry_next;
        end
    end

    assign chain[0] = entry_reg;

    // One cell per frustum plane.
    for (genvar g = 0; g < PLANE_COUNT; g++)
    begin : g_cell
        fsc_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .plane    (fsc_pkg::plane_coef(col1_reg, col2_reg, col3_reg, col4_reg, g)),
            .item_in  (chain[g]),
            .item_out (chain[g+1])
        );
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            visible_reg   <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= chain[PLANE_COUNT].valid;
            visible_reg   <= chain[PLANE_COUNT].visible;
        end
    end

    assign out_valid = out_valid_reg;
    assign visible   = visible_reg;

`ifndef NO_ASSERTIONS
    // A result reaching the end of the chain is presented on the next advance.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && chain[PLANE_COUNT].valid |=> out_valid)
        else $error("frustum_sphere_cull_core: result dropped at output");

    // The input is held off only while a result waits at the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("frustum_sphere_cull_core: input stalled without cause");

    // An accepted object enters the entry register.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> entry_reg.valid && entry_reg.visible)
        else $error("frustum_sphere_cull_core: accepted object not captured");
`endif

endmodule

@@ rtl/core/fsc_cell.sv @@
// ----------------------------------------------------------------------------
// fsc_cell: one plane test of the culling chain
// Six pipeline stages compute d = n.p + w, then compare d*d with r*r*|n|^2
// and clear the visible flag of the passing object when the plane rejects it.
// ----------------------------------------------------------------------------
module fsc_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  fsc_pkg::plane_t plane,
    input  fsc_pkg::item_t  item_in,
    output fsc_pkg::item_t  item_out
);

    localparam int COEF_W = fsc_pkg::COEF_W;
    localparam int FRAC_W = fsc_pkg::FRAC_W;
    localparam int PROD_W = fsc_pkg::PROD_W;
    localparam int D_W    = fsc_pkg::D_W;
    localparam int AD_W   = fsc_pkg::AD_W;
    localparam int AL_W   = fsc_pkg::AL_W;
    localparam int AH_W   = fsc_pkg::AH_W;
    localparam int DPP_W  = fsc_pkg::DPP_W;
    localparam int SQ_W   = fsc_pkg::SQ_W;
    localparam int NN_W   = fsc_pkg::NN_W;
    localparam int R2_W   = fsc_pkg::R2_W;
    localparam int RL_W   = fsc_pkg::RL_W;
    localparam int RPP_W  = fsc_pkg::RPP_W;
    localparam int SQR_W  = fsc_pkg::SQR_W;

    // Plane coefficients and squared normal length, refreshed every cycle.
    fsc_pkg::plane_t   coef_reg;
    logic [NN_W-1:0]   nn_reg;
    logic [NN_W-1:0]   nn_next;
    logic signed [SQ_W-1:0] sqx;
    logic signed [SQ_W-1:0] sqy;
    logic signed [SQ_W-1:0] sqz;

    // Item records along the six stages.
    fsc_pkg::item_t s1_reg, s2_reg, s3_reg, s4_reg, s5_reg, s6_reg;

    // Stage data.
    logic signed [PROD_W-1:0] px_reg, py_reg, pz_reg;
    logic signed [PROD_W-1:0] px_next, py_next, pz_next;
    logic signed [D_W-1:0]    wsh_reg, wsh_next;
    logic signed [D_W-1:0]    d_reg, d_next;
    logic [AD_W-1:0]          ad_reg, ad_next;
    logic                     neg3_reg, neg4_reg, neg5_reg;
    logic [DPP_W-1:0]         hh_reg, hl_reg, ll_reg;
    logic [DPP_W-1:0]         hh_next, hl_next, ll_next;
    logic [RPP_W-1:0]         rph_reg, rpl_reg, rph_next, rpl_next;
    logic [SQR_W-1:0]         dsq_reg, rsq_reg, dsq_next, rsq_next;
    logic [AH_W-1:0]          ah;
    logic [AL_W-1:0]          al;
    logic                     reject;
    fsc_pkg::item_t           s6_next;

    // Squared normal length from the registered plane.
    always_comb
    begin
        sqx     = coef_reg.nx * coef_reg.nx;
        sqy     = coef_reg.ny * coef_reg.ny;
        sqz     = coef_reg.nz * coef_reg.nz;
        nn_next = NN_W'(unsigned'(sqx)) + NN_W'(unsigned'(sqy)) + NN_W'(unsigned'(sqz));
    end

    always_ff @(posedge clk)
    begin
        coef_reg <= plane;
        nn_reg   <= nn_next;
    end

    // Stage 1: normal times position, offset scaled to the product format.
    always_comb
    begin
        px_next  = coef_reg.nx * item_in.pos_x;
        py_next  = coef_reg.ny * item_in.pos_y;
        pz_next  = coef_reg.nz * item_in.pos_z;
        wsh_next = {{(D_W-COEF_W-FRAC_W){coef_reg.w[COEF_W-1]}}, coef_reg.w, {FRAC_W{1'b0}}};
    end

    // Stage 2: signed distance. Stage 3: magnitude of a negative distance.
    always_comb
    begin
        d_next  = D_W'(px_reg) + D_W'(py_reg) + D_W'(pz_reg) + wsh_reg;
        ad_next = d_reg[D_W-1] ? AD_W'(-d_reg) : '0;
    end

    // Stage 4: partial products of d*d and of r*r*|n|^2.
    always_comb
    begin
        ah       = ad_reg[AD_W-1 -: AH_W];
        al       = ad_reg[AL_W-1:0];
        hh_next  = ah * ah;
        hl_next  = ah * al;
        ll_next  = al * al;
        rph_next = s3_reg.r2[R2_W-1:RL_W] * nn_reg;
        rpl_next = s3_reg.r2[RL_W-1:0] * nn_reg;
    end

    // Stage 5: assemble both squares. The cross term carries the factor two.
    always_comb
    begin
        dsq_next = (SQR_W'(hh_reg) << (2 * AL_W)) + (SQR_W'(hl_reg) << (AL_W + 1))
                   + SQR_W'(ll_reg);
        rsq_next = (SQR_W'(rph_reg) << RL_W) + SQR_W'(rpl_reg);
    end

    // Stage 6: the plane rejects a sphere lying fully on its negative side.
    always_comb
    begin
        reject  = s5_reg.has_sphere && neg5_reg && (nn_reg != '0) && (dsq_reg > rsq_reg);
        s6_next = s5_reg;
        s6_next.visible = s5_reg.visible && !reject;
    end

    // Stage registers, all moving together when the chain advances.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
            s2_reg <= '0;
            s3_reg <= '0;
            s4_reg <= '0;
            s5_reg <= '0;
            s6_reg <= '0;
        end
        else if (advance)
        begin
            s1_reg <= item_in;
            s2_reg <= s1_reg;
            s3_reg <= s2_reg;
            s4_reg <= s3_reg;
            s5_reg <= s4_reg;
            s6_reg <= s6_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            px_reg   <= px_next;
            py_reg   <= py_next;
            pz_reg   <= pz_next;
            wsh_reg  <= wsh_next;
            d_reg    <= d_next;
            ad_reg   <= ad_next;
            neg3_reg <= d_reg[D_W-1];
            neg4_reg <= neg3_reg;
            neg5_reg <= neg4_reg;
            hh_reg   <= hh_next;
            hl_reg   <= hl_next;
            ll_reg   <= ll_next;
            rph_reg  <= rph_next;
            rpl_reg  <= rpl_next;
            dsq_reg  <= dsq_next;
            rsq_reg  <= rsq_next;
        end
    end

    assign item_out = s6_reg;

`ifndef NO_ASSERTIONS
    // An object entering the cell moves one stage on each advance.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && s1_reg.valid |=> s2_reg.valid)
        else $error("fsc_cell: object lost between stages");

    // A cell can only clear the visible flag, never set it.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && s5_reg.valid && !s5_reg.visible |=> !item_out.visible)
        else $error("fsc_cell: visible flag set by a plane test");

    // An object without a sphere is never culled.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_out.valid && !item_out.has_sphere |-> item_out.visible)
        else $error("fsc_cell: object without sphere culled");

    // The cell output holds while the chain is stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(item_out))
        else $error("fsc_cell: output moved during stall");
`endif

endmodule
